/* design/spap_pkg.sv */
// ----------------------------------------------------------------------------
// spap_pkg
// Shared constants, codes and types of the slot pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package spap_pkg;

	localparam int POOL_SLOTS = 64;
	localparam int SLOT_W     = $clog2(POOL_SLOTS);
	localparam int CNT_W      = $clog2(POOL_SLOTS) + 1;
	localparam int PICK_W     = 16;
	localparam int STATUS_W   = 2;

	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_FRESH    = 2'd0,
		STATUS_REUSED   = 2'd1,
		STATUS_RELEASED = 2'd2,
		STATUS_REJECTED = 2'd3
	} status_t;

	typedef struct packed {
		logic              capture;
		logic              rel_mode;
		logic [SLOT_W-1:0] rel_id;
		logic [SLOT_W-1:0] pick_pos;
		logic [CNT_W-1:0]  live_count;
		logic              append;
		logic [SLOT_W-1:0] append_id;
		logic              compact;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* design/slot_pool_allocator_with_steal_unit.sv */
// ----------------------------------------------------------------------------
// slot_pool_allocator_with_steal_unit
// Slot id pool: free stack in RAM, ordered live list in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. kind selects
//   allocate or release; release_slot names the id to free; victim_pick
//   chooses the live position to reuse when no slot is free.
//   Each request yields exactly one result: done is high for one cycle with
//   slot_id, status and live_total valid. The receiver cannot stall.
//   Timing: done, slot_id, status and live_total are registered from the
//   execute state; busy is high in that state, so a new request is taken
//   only once the last one has left it. This is set by the registered read
//   of the free stack RAM and the registered match flags of the live cells.
//   The result of one request is shown while the next one may be accepted.
//   Reset: all ids are free (highest id popped first), nothing is live.
//   No clearing pass is needed; a low-water mark stands in for the initial
//   contents of the free stack.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_pool_allocator_with_steal_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          kind,
	input  wire logic [spap_pkg::SLOT_W-1:0]   release_slot,
	input  wire logic [spap_pkg::PICK_W-1:0]   victim_pick,
	output logic                               done,
	output logic      [spap_pkg::SLOT_W-1:0]   slot_id,
	output logic      [spap_pkg::STATUS_W-1:0] status,
	output logic      [spap_pkg::CNT_W-1:0]    live_total
);

	import spap_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t             state_q;
	logic               kind_q;
	logic [SLOT_W-1:0]  rel_q;
	logic [SLOT_W-1:0]  rd_addr_q;
	logic [CNT_W-1:0]   live_count_q;
	logic [CNT_W-1:0]   low_water_q;
	logic               done_q;
	logic [SLOT_W-1:0]  slot_id_q;
	status_t            status_q;
	logic [CNT_W-1:0]   live_total_q;

	logic               accept;
	logic               exec;
	logic [CNT_W-1:0]   free_total;
	logic [CNT_W-1:0]   free_top;
	logic               has_free;
	logic               found;
	logic [SLOT_W-1:0]  pop_id;
	logic [SLOT_W-1:0]  ram_rdata;
	logic [SLOT_W-1:0]  victim_id;
	logic               do_pop;
	logic               do_push;
	cell_ctl_t          ctl;

	logic [SLOT_W-1:0]  cell_id  [POOL_SLOTS];
	logic [SLOT_W-1:0]  cell_sel [POOL_SLOTS];
	logic [POOL_SLOTS-1:0] hits;
	logic [POOL_SLOTS-1:0] shifts;

	assign accept     = start && (state_q == ST_IDLE);
	assign exec       = (state_q == ST_EXEC);
	assign busy       = exec;
	assign free_total = CNT_W'(POOL_SLOTS) - live_count_q;
	assign free_top   = free_total - CNT_W'(1);
	assign has_free   = live_count_q < CNT_W'(POOL_SLOTS);
	assign found      = |hits;
	assign pop_id     = ({1'b0, rd_addr_q} < low_water_q) ? rd_addr_q : ram_rdata;
	assign do_pop     = exec && (kind_q == KIND_ALLOC) && has_free;
	assign do_push    = exec && (kind_q == KIND_RELEASE) && found;

	always_comb begin
		ctl            = '0;
		ctl.capture    = accept;
		ctl.rel_mode   = (kind == KIND_RELEASE);
		ctl.rel_id     = release_slot;
		ctl.pick_pos   = SLOT_W'(victim_pick % POOL_SLOTS);
		ctl.live_count = live_count_q;
		ctl.append     = do_pop;
		ctl.append_id  = pop_id;
		ctl.compact    = do_push;
	end

	spap_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(POOL_SLOTS)
	) u_free_stack (
		.clk  (clk),
		.we   (do_push),
		.waddr(free_total[SLOT_W-1:0]),
		.wdata(rel_q),
		.raddr(free_top[SLOT_W-1:0]),
		.rdata(ram_rdata)
	);

	for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
		logic [SLOT_W-1:0] nxt;
		if (i == POOL_SLOTS - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_id[i+1];
		end
		assign shifts[i] = |hits[i:0];

		spap_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.pos    (SLOT_W'(i)),
			.shift  (shifts[i]),
			.next_id(nxt),
			.id     (cell_id[i]),
			.hit    (hits[i]),
			.sel_id (cell_sel[i])
		);
	end

	always_comb begin
		victim_id = '0;
		for (int i = 0; i < POOL_SLOTS; i++) begin
			victim_id = victim_id | cell_sel[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			live_count_q <= '0;
			low_water_q  <= CNT_W'(POOL_SLOTS);
			done_q       <= 1'b0;
		end else begin
			done_q <= exec;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					if (do_pop) begin
						live_count_q <= live_count_q + CNT_W'(1);
						if (free_top < low_water_q) begin
							low_water_q <= free_top;
						end
					end else if (do_push) begin
						live_count_q <= live_count_q - CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= kind;
			rel_q     <= release_slot;
			rd_addr_q <= free_top[SLOT_W-1:0];
		end
		if (exec) begin
			if (kind_q == KIND_ALLOC) begin
				if (has_free) begin
					slot_id_q    <= pop_id;
					status_q     <= STATUS_FRESH;
					live_total_q <= live_count_q + CNT_W'(1);
				end else begin
					slot_id_q    <= victim_id;
					status_q     <= STATUS_REUSED;
					live_total_q <= live_count_q;
				end
			end else begin
				slot_id_q <= rel_q;
				if (found) begin
					status_q     <= STATUS_RELEASED;
					live_total_q <= live_count_q - CNT_W'(1);
				end else begin
					status_q     <= STATUS_REJECTED;
					live_total_q <= live_count_q;
				end
			end
		end
	end

	assign done       = done_q;
	assign slot_id    = slot_id_q;
	assign status     = status_q;
	assign live_total = live_total_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		live_count_q <= CNT_W'(POOL_SLOTS))
		else $error("live count above pool size");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("request finished without a result");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hits))
		else $error("more than one live cell matched");

	a_reuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_q == STATUS_REUSED)) |-> (live_total == CNT_W'(POOL_SLOTS)))
		else $error("slot reused while free slots remain");

	a_low_water: assert property (@(posedge clk) disable iff (!arst_n)
		low_water_q <= free_total)
		else $error("low-water mark above free count");

endmodule

`default_nettype wire

/* design/spap_ram.sv */
// ----------------------------------------------------------------------------
// spap_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* design/spap_cell.sv */
// ----------------------------------------------------------------------------
// spap_cell
// One live list position: holds an id, matches a request, shifts down on
// compaction and takes a new id on append.
// ----------------------------------------------------------------------------
`default_nettype none

module spap_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire spap_pkg::cell_ctl_t       ctl,
	input  wire logic [spap_pkg::SLOT_W-1:0] pos,
	input  wire logic                      shift,
	input  wire logic [spap_pkg::SLOT_W-1:0] next_id,
	output logic      [spap_pkg::SLOT_W-1:0] id,
	output logic                           hit,
	output logic      [spap_pkg::SLOT_W-1:0] sel_id
);

	import spap_pkg::*;

	logic [SLOT_W-1:0] id_q;
	logic              hit_q;
	logic              in_live;

	assign in_live = {1'b0, pos} < ctl.live_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.capture) begin
			hit_q <= ctl.rel_mode ? (in_live && (id_q == ctl.rel_id))
			                      : (pos == ctl.pick_pos);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.append && ({1'b0, pos} == ctl.live_count)) begin
			id_q <= ctl.append_id;
		end else if (ctl.compact && shift) begin
			id_q <= next_id;
		end
	end

	assign id     = id_q;
	assign hit    = hit_q;
	assign sel_id = hit_q ? id_q : '0;

endmodule

`default_nettype wire
